// File: src/tpm_pkg.sv
`default_nettype none
package tpm_pkg;

  localparam int NUM_COMP = 3;

  localparam logic [1:0] FORM_SCALAR   = 2'd0;
  localparam logic [1:0] FORM_VECTOR   = 2'd1;
  localparam logic [1:0] FORM_INTEGRAL = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_INDEX = 2'd1;
  localparam logic [1:0] ERR_SAT   = 2'd2;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_ELEMENT = 1'b1;

  localparam logic CFG_FORM  = 1'b0;
  localparam logic CFG_NODES = 1'b1;

  localparam logic [4:0] DIV_INTEGRAL = 5'd4;
  localparam logic [4:0] DIV_MASS     = 5'd20;

  typedef struct packed {
    logic               start;
    logic        [31:0] ms;
    logic        [31:0] vol;
    logic signed [63:0] sum;
    logic        [4:0]  divisor;
  } scale_req_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic signed [63:0] value;
  } scale_res_t;

endpackage
`default_nettype wire

// File: src/tpm_node_mem.sv
`default_nettype none
module tpm_node_mem #(
  parameter int AW    = 12,
  parameter int DEPTH = 4096,
  parameter int VW    = 32
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic [1:0]             wr_comp,
  input  wire logic [VW-1:0]          wr_left,
  input  wire logic [VW-1:0]          wr_right,
  input  wire logic [AW-1:0]          rd_addr,
  output      logic [2:0][VW-1:0]     rd_left,
  output      logic [2:0][VW-1:0]     rd_right
);

  logic [2:0][VW-1:0] left_mem  [DEPTH];
  logic [2:0][VW-1:0] right_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr][wr_comp]  <= wr_left;
      right_mem[wr_addr][wr_comp] <= wr_right;
    end
    rd_left  <= left_mem[rd_addr];
    rd_right <= right_mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: src/tpm_scale.sv
`default_nettype none
module tpm_scale
  import tpm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire scale_req_t req,
  output      scale_res_t res
);

  typedef enum logic [1:0] {S_IDLE, S_MV, S_MUL, S_DIV} state_t;

  state_t        state;
  logic [31:0]   ms;
  logic [31:0]   vol;
  logic          neg;
  logic [63:0]   mag;
  logic [63:0]   mv;
  logic [63:0]   pp;
  logic [1:0]    pp_sh;
  logic [127:0]  prod;
  logic [127:0]  quo;
  logic [4:0]    dvs;
  logic [4:0]    rem;
  logic [4:0]    cnt;
  logic [4:0]    rem_next;
  logic [7:0]    qbits;
  logic [127:0]  quo_next;
  logic [127:0]  pp_ext;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   m;
  logic          sat_next;
  logic signed [63:0] value_next;

  always_comb begin
    logic [5:0] cur;
    logic [4:0] r;
    r = rem;
    qbits = '0;
    for (int k = 0; k < 8; k++) begin
      cur = {r, prod[127-k]};
      if (cur >= {1'b0, dvs}) begin
        r = 5'(cur - {1'b0, dvs});
        qbits[7-k] = 1'b1;
      end else begin
        r = cur[4:0];
      end
    end
    rem_next = r;
  end

  assign quo_next = {quo[119:0], qbits};
  assign m        = quo_next[63:0];
  assign mul_a    = cnt[1] ? mv[63:32] : mv[31:0];
  assign mul_b    = cnt[0] ? mag[63:32] : mag[31:0];

  always_comb begin
    case (pp_sh)
      2'd0:    pp_ext = {64'b0, pp};
      2'd1:    pp_ext = {32'b0, pp, 32'b0};
      2'd2:    pp_ext = {pp, 64'b0};
      default: pp_ext = '0;
    endcase
  end

  always_comb begin
    sat_next   = 1'b0;
    value_next = neg ? -$signed(m) : $signed(m);
    if (quo_next[127:64] != '0) begin
      sat_next   = 1'b1;
      value_next = neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else if (!neg && m[63]) begin
      sat_next   = 1'b1;
      value_next = {1'b0, {63{1'b1}}};
    end else if (neg && m > {1'b1, 63'b0}) begin
      sat_next   = 1'b1;
      value_next = {1'b1, 63'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            ms    <= req.ms;
            vol   <= req.vol;
            neg   <= req.sum[63];
            mag   <= req.sum[63] ? 64'(-req.sum) : 64'(req.sum);
            dvs   <= req.divisor;
            state <= S_MV;
          end
        end
        S_MV: begin
          mv    <= 64'(ms) * 64'(vol);
          prod  <= '0;
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (cnt < 5'd4) begin
            pp    <= 64'(mul_a) * 64'(mul_b);
            pp_sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
          end
          if (cnt != '0) begin
            prod <= prod + pp_ext;
          end
          if (cnt == 5'd4) begin
            cnt   <= '0;
            rem   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_DIV: begin
          prod <= {prod[119:0], 8'b0};
          rem  <= rem_next;
          quo  <= quo_next;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            res.done  <= 1'b1;
            res.sat   <= sat_next;
            res.value <= value_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/tet_p1_mass_form_accumulator.sv
// Accumulates a mass-type bilinear form over P1 tetrahedra.
// Input beats (s_axis) are either node writes or element beats, as given by
// tuser. A node write stores one component of the left and right values of a
// node. An element beat reads its four vertices from the
// node memory, one vertex per cycle. In the mass forms it then forms the
// weighted sum of floored products with three multipliers (one vertex pair
// per cycle, 16 pairs); in the integral form it sums the first left component
// of the four vertices. It then scales by Ms times volume and divides by 4 or
// 20 in a shared unit that works 8 quotient bits per cycle. The accumulator
// is updated when the unit returns its result, and a finish state then ends
// the element; a new beat is accepted only after that. An invalid element, or
// one under the unused form, goes straight to the finish state.
// The block works on one beat at a time and drops tready while busy.
// An element beat with tlast emits one result beat on m_axis: the total in
// tdata and the status in tuser, then clears the total and the status.
// The result register holds a beat until taken; a stalled receiver only
// delays the block when the next result is due. Reset clears the total,
// the status and the registers (form 0, 4096 nodes); node contents are
// undefined until written.
`default_nettype none
module tet_p1_mass_form_accumulator
  import tpm_pkg::*;
#(
  parameter int MAX_NODES   = 4096,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_index,
  input  wire logic [12:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // node_index, component, left_value, right_value, node_a, node_b, node_c,
  // node_d, ms_value, volume, zero padding
  input  wire logic [191:0] s_axis_tdata,
  // kind
  input  wire logic [0:0]   s_axis_tuser,
  input  wire logic         s_axis_tlast,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // total
  output      logic [63:0]  m_axis_tdata,
  // status
  output      logic [1:0]   m_axis_tuser
);

  localparam int AW   = $clog2(MAX_NODES);
  localparam int VW   = VALUE_WIDTH;
  localparam int FRAC = VW - 2;
  localparam int SW   = VW + 7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GATHER, ST_INTEG, ST_PAIRS, ST_SCALE, ST_WAIT, ST_FINISH
  } state_t;

  state_t             state;
  logic [1:0]         form;
  logic [12:0]        nodes_used;
  logic signed [63:0] acc;
  logic [1:0]         err;
  logic               last_r;
  logic [31:0]        ms_r;
  logic [31:0]        vol_r;
  logic [3:0][11:0]   vtx;
  logic [4:0]         cnt;
  logic signed [VW-1:0]   gl [4][NUM_COMP];
  logic signed [VW-1:0]   gr [4][NUM_COMP];
  logic signed [2*VW-1:0] prod [NUM_COMP];
  logic               diag;
  logic signed [SW-1:0] s_sum;
  scale_req_t         sreq;
  scale_res_t         sres;

  logic [11:0]        in_index;
  logic [1:0]         in_comp;
  logic [3:0][11:0]   in_vtx;
  logic               accept;
  logic [3:0]         vtx_ok;
  logic               idx_ok;
  logic               mem_wr;
  logic [AW-1:0]      rd_addr;
  logic [2:0][VW-1:0] rd_left;
  logic [2:0][VW-1:0] rd_right;
  logic signed [SW-1:0] dot;
  logic signed [SW-1:0] integ;
  logic signed [64:0] acc_sum;
  logic               out_free;
  logic               out_load;

  function automatic logic index_ok(input logic [11:0] idx, input logic [12:0] count);
    return ({1'b0, idx} < count) && (32'(idx) < MAX_NODES);
  endfunction

  assign in_index = s_axis_tdata[11:0];
  assign in_comp  = s_axis_tdata[13:12];
  assign in_vtx   = s_axis_tdata[125:78];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = (state == ST_FINISH) && last_r && out_free;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vtx_ok[k] = index_ok(in_vtx[k], nodes_used);
    end
  end

  assign idx_ok = index_ok(in_index, nodes_used);
  assign mem_wr = accept && (s_axis_tuser[0] == KIND_WRITE) && idx_ok
                  && (32'(in_comp) < NUM_COMP);
  assign rd_addr = AW'(vtx[cnt[1:0]]);

  tpm_node_mem #(.AW(AW), .DEPTH(MAX_NODES), .VW(VW)) u_mem (
    .clk      (clk),
    .wr_en    (mem_wr),
    .wr_addr  (AW'(in_index)),
    .wr_comp  (in_comp),
    .wr_left  (s_axis_tdata[14 +: VW]),
    .wr_right (s_axis_tdata[46 +: VW]),
    .rd_addr  (rd_addr),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  tpm_scale u_scale (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .res (sres)
  );

  always_comb begin
    dot = '0;
    for (int c = 0; c < NUM_COMP; c++) begin
      if (c == 0 || form == FORM_VECTOR) begin
        dot = dot + SW'(prod[c] >>> FRAC);
      end
    end
    if (diag) begin
      dot = dot <<< 1;
    end
  end

  always_comb begin
    integ = '0;
    for (int k = 0; k < 4; k++) begin
      integ = integ + SW'(gl[k][0]);
    end
  end

  assign acc_sum = {acc[63], acc} + {sres.value[63], sres.value};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      form          <= FORM_SCALAR;
      nodes_used    <= 13'd4096;
      acc           <= '0;
      err           <= ERR_OK;
      m_axis_tvalid <= 1'b0;
      sreq.start    <= 1'b0;
    end else begin
      sreq.start <= (state == ST_INTEG) || (state == ST_SCALE);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FORM:  form       <= cfg_data[1:0];
          CFG_NODES: nodes_used <= cfg_data;
          default:   ;
        endcase
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_r <= s_axis_tlast;
            ms_r   <= s_axis_tdata[157:126];
            vol_r  <= s_axis_tdata[189:158];
            vtx    <= in_vtx;
            cnt    <= '0;
            if (s_axis_tuser[0] == KIND_WRITE) begin
              if (!idx_ok) begin
                err <= ERR_INDEX;
              end
            end else if (vtx_ok != 4'hf) begin
              err   <= ERR_INDEX;
              state <= ST_FINISH;
            end else if (form == FORM_SCALAR || form == FORM_VECTOR
                         || form == FORM_INTEGRAL) begin
              state <= ST_GATHER;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_GATHER: begin
          if (cnt != '0) begin
            for (int c = 0; c < NUM_COMP; c++) begin
              gl[2'(cnt - 5'd1)][c] <= $signed(rd_left[c]);
              gr[2'(cnt - 5'd1)][c] <= $signed(rd_right[c]);
            end
          end
          if (cnt == 5'd4) begin
            cnt   <= '0;
            s_sum <= '0;
            state <= (form == FORM_INTEGRAL) ? ST_INTEG : ST_PAIRS;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_INTEG: begin
          sreq.ms      <= ms_r;
          sreq.vol     <= vol_r;
          sreq.sum     <= 64'(integ);
          sreq.divisor <= DIV_INTEGRAL;
          state        <= ST_WAIT;
        end
        ST_PAIRS: begin
          if (cnt < 5'd16) begin
            for (int c = 0; c < NUM_COMP; c++) begin
              prod[c] <= gl[cnt[3:2]][c] * gr[cnt[1:0]][c];
            end
            diag <= (cnt[3:2] == cnt[1:0]);
          end
          if (cnt != '0) begin
            s_sum <= s_sum + dot;
          end
          if (cnt == 5'd16) begin
            state <= ST_SCALE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_SCALE: begin
          sreq.ms      <= ms_r;
          sreq.vol     <= vol_r;
          sreq.sum     <= 64'(s_sum);
          sreq.divisor <= DIV_MASS;
          state        <= ST_WAIT;
        end
        ST_WAIT: begin
          if (sres.done) begin
            if (acc_sum[64] != acc_sum[63]) begin
              acc <= sres.value[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            end else begin
              acc <= acc_sum[63:0];
            end
            if ((sres.sat || acc_sum[64] != acc_sum[63]) && err == ERR_OK) begin
              err <= ERR_SAT;
            end
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!last_r) begin
            state <= ST_IDLE;
          end else if (out_load) begin
            m_axis_tdata  <= acc;
            m_axis_tuser  <= err;
            acc           <= '0;
            err           <= ERR_OK;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("result status carries an undefined code");

  a_scale_in_wait: assert property (@(posedge clk) disable iff (rst)
    sres.done |-> state == ST_WAIT)
    else $error("scale result arrived with no element waiting");

  a_pass_clear: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (acc == '0 && err == ERR_OK))
    else $error("total or status not cleared at the end of a pass");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !mem_wr)
    else $error("node memory written while an element is in progress");

endmodule
`default_nettype wire
